// ===== hw/rtl/tsl_pkg.sv =====
package tsl_pkg;

   // Default converter width for the button ladder and the light sensor.
   localparam int ADC_BITS_DEFAULT = 10;

   // Widths of the fixed fields.
   localparam int TIME_BITS   = 32;
   localparam int PERIOD_BITS = 16;
   localparam int THRESH_BITS = 10;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = PERIOD_BITS;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_TURN_HALF   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HAZARD_HALF = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRIGHT      = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [PERIOD_BITS-1:0] TURN_HALF_RESET   = 16'd500;
   localparam logic [PERIOD_BITS-1:0] HAZARD_HALF_RESET = 16'd100;
   localparam logic [THRESH_BITS-1:0] BRIGHT_RESET      = 10'd500;

   // Open windows of the button ladder; both bounds are exclusive.
   localparam int LEFT_LO     = 500;
   localparam int LEFT_HI     = 520;
   localparam int RIGHT_LO    = 680;
   localparam int RIGHT_HI    = 700;
   localparam int HAZARD_LO   = 760;
   localparam int HAZARD_HI   = 780;
   localparam int BRAKE_LO    = 810;
   localparam int BRAKE_HI    = 830;
   localparam int POSITION_LO = 850;
   localparam int POSITION_HI = 860;

   // Decoded button; the turn buttons share their codes with the turn modes.
   typedef enum logic [2:0] {
      BTN_NONE     = 3'd0,
      BTN_LEFT     = 3'd1,
      BTN_RIGHT    = 3'd2,
      BTN_HAZARD   = 3'd3,
      BTN_BRAKE    = 3'd4,
      BTN_POSITION = 3'd5
   } btn_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_LEFT   = 2'd1,
      MODE_RIGHT  = 2'd2,
      MODE_HAZARD = 2'd3
   } mode_type;

   // Lamp drives of one result item.
   typedef struct packed {
      logic     left_amber;
      logic     right_amber;
      logic     brake_lamp;
      logic     position_lamps;
      mode_type turn_mode_now;
   } lamps_type;

   // Configuration shared by the lamp core.
   typedef struct packed {
      logic [PERIOD_BITS-1:0] turn_half;
      logic [PERIOD_BITS-1:0] hazard_half;
      logic [THRESH_BITS-1:0] bright;
   } cfg_type;

endpackage

// ===== hw/rtl/tsl_decode.sv =====
module tsl_decode import tsl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic [ADC_BITS-1:0] level,
   output btn_type             button
);

   // Returns true when the level lies strictly between the two bounds.
   function automatic logic in_window(input logic [ADC_BITS-1:0] lv, input int lo,
                                      input int hi);
      in_window = (lv > ADC_BITS'(lo)) && (lv < ADC_BITS'(hi));
   endfunction

   // Fixed ladder windows; a level outside every window is no button.
   always_comb begin
      if (in_window(level, LEFT_LO, LEFT_HI)) begin
         button = BTN_LEFT;
      end else if (in_window(level, RIGHT_LO, RIGHT_HI)) begin
         button = BTN_RIGHT;
      end else if (in_window(level, HAZARD_LO, HAZARD_HI)) begin
         button = BTN_HAZARD;
      end else if (in_window(level, BRAKE_LO, BRAKE_HI)) begin
         button = BTN_BRAKE;
      end else if (in_window(level, POSITION_LO, POSITION_HI)) begin
         button = BTN_POSITION;
      end else begin
         button = BTN_NONE;
      end
   end

endmodule

// ===== hw/rtl/tsl_core.sv =====
module tsl_core import tsl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  cfg_type              cfg,
   input  logic [ADC_BITS-1:0]  button_level,
   input  logic [ADC_BITS-1:0]  light_level,
   input  logic [TIME_BITS-1:0] now_ms,
   output lamps_type            lamps
);

   btn_type                button;
   btn_type                prev_button_ff, prev_button_in;
   mode_type               mode_ff, mode_in;
   logic                   phase_ff, phase_in;
   logic [TIME_BITS-1:0]   last_toggle_ff, last_toggle_in;
   logic                   pos_flag_ff, pos_flag_in;
   logic                   pressed;
   logic [PERIOD_BITS-1:0] half;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   bright;

   tsl_decode #(.ADC_BITS(ADC_BITS)) u_decode (
      .level  (button_level),
      .button (button)
   );

   // Press detection and the mode and position toggles.
   always_comb begin
      pressed     = (button != BTN_NONE) && (button != prev_button_ff);
      mode_in     = mode_ff;
      pos_flag_in = pos_flag_ff;
      if (pressed) begin
         case (button)
            BTN_LEFT, BTN_RIGHT, BTN_HAZARD: begin
               mode_in = (mode_ff == mode_type'(button[1:0])) ? MODE_OFF
                                                             : mode_type'(button[1:0]);
            end
            BTN_POSITION: begin
               pos_flag_in = ~pos_flag_ff;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Blink timing with wrapping elapsed time against the half period.
   always_comb begin
      half           = (mode_in == MODE_HAZARD) ? cfg.hazard_half : cfg.turn_half;
      elapsed        = now_ms - last_toggle_ff;
      phase_in       = phase_ff;
      last_toggle_in = last_toggle_ff;
      if ((mode_in != MODE_OFF) && (elapsed > {{(TIME_BITS-PERIOD_BITS){1'b0}}, half})) begin
         phase_in       = ~phase_ff;
         last_toggle_in = now_ms;
      end
      prev_button_in = button;
   end

   // Lamp drives for this item.
   always_comb begin
      bright = light_level > ADC_BITS'(cfg.bright);
      lamps.left_amber     = phase_in && ((mode_in == MODE_LEFT) || (mode_in == MODE_HAZARD));
      lamps.right_amber    = phase_in && ((mode_in == MODE_RIGHT) || (mode_in == MODE_HAZARD));
      lamps.brake_lamp     = (button == BTN_BRAKE);
      lamps.position_lamps = pos_flag_in ^ bright;
      lamps.turn_mode_now  = mode_in;
   end

   // State advances only when an item passes through.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= BTN_NONE;
         mode_ff        <= MODE_OFF;
         phase_ff       <= 1'b0;
         last_toggle_ff <= '0;
         pos_flag_ff    <= 1'b0;
      end else if (fire) begin
         prev_button_ff <= prev_button_in;
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         last_toggle_ff <= last_toggle_in;
         pos_flag_ff    <= pos_flag_in;
      end
   end

   // The mode changes only when an item is processed.
   a_mode_on_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff))
      else $error("turn mode changed without an item");

   // With the mode off the blink phase and its timestamp hold.
   a_phase_hold_off: assert property (@(posedge clock) disable iff (reset)
      (fire && (mode_in == MODE_OFF)) |=> ($stable(phase_ff) && $stable(last_toggle_ff)))
      else $error("blink phase moved while mode is off");

   // A phase toggle always records the item's timestamp.
   a_toggle_stamp: assert property (@(posedge clock) disable iff (reset)
      (fire && (phase_in != phase_ff)) |=> (last_toggle_ff == $past(now_ms)))
      else $error("blink toggle without timestamp update");

endmodule

// ===== hw/rtl/vehicle_turn_signal_light_controller.sv =====
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | button_level, light_level, now_ms
// rsp     | out       | rsp_valid/rsp_stall | lamps and turn mode
// csr     | in        | csr_write          | csr_index, csr_wdata
//
// The result of an accepted item passes through the input register, then the
// decode and blink logic into the result register.
// One item is accepted every cycle while the result side takes items.
// Synchronous reset clears the state and the valid flags and loads the
// configuration defaults.
// A stalled result holds the result register, and the input register then
// raises req_stall once it holds an item too.
module vehicle_turn_signal_light_controller import tsl_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ADC_BITS-1:0]      req_button_level,
   input  logic [ADC_BITS-1:0]      req_light_level,
   input  logic [TIME_BITS-1:0]     req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_left_amber,
   output logic                     rsp_right_amber,
   output logic                     rsp_brake_lamp,
   output logic                     rsp_position_lamps,
   output logic [1:0]               rsp_turn_mode_now,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [ADC_BITS-1:0]   button_ff;
   logic [ADC_BITS-1:0]   light_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic                  out_valid_ff, out_valid_in;
   lamps_type             out_ff;
   lamps_type             lamps;
   logic                  advance;
   logic                  fire;
   logic                  take;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_half   <= TURN_HALF_RESET;
         cfg_ff.hazard_half <= HAZARD_HALF_RESET;
         cfg_ff.bright      <= BRIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TURN_HALF:   cfg_ff.turn_half   <= csr_wdata;
            CSR_HAZARD_HALF: cfg_ff.hazard_half <= csr_wdata;
            CSR_BRIGHT:      cfg_ff.bright      <= csr_wdata[THRESH_BITS-1:0];
            default:         cfg_ff.bright      <= cfg_ff.bright;
         endcase
      end
   end

   // Handshake: the result register frees up when empty or taken.
   always_comb begin
      advance      = !out_valid_ff || !rsp_stall;
      fire         = in_valid_ff && advance;
      req_stall    = in_valid_ff && !advance;
      take         = req_valid && !req_stall;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         button_ff <= req_button_level;
         light_ff  <= req_light_level;
         now_ff    <= req_now_ms;
      end
   end

   tsl_core #(.ADC_BITS(ADC_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cfg          (cfg_ff),
      .button_level (button_ff),
      .light_level  (light_ff),
      .now_ms       (now_ff),
      .lamps        (lamps)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= lamps;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_amber     = out_ff.left_amber;
   assign rsp_right_amber    = out_ff.right_amber;
   assign rsp_brake_lamp     = out_ff.brake_lamp;
   assign rsp_position_lamps = out_ff.position_lamps;
   assign rsp_turn_mode_now  = out_ff.turn_mode_now;

   // The input side stalls only while it holds an item that cannot move.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled with room downstream");

   // A processed item always shows up as a result in the next cycle.
   a_fire_to_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed item lost");

   // A held result does not vanish without being taken.
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result dropped");

endmodule
